/* hw/rtl/ina_pkg.sv */
// Shared constants for the object number allocator: defaults, action and status codes.
`default_nettype none
package ina_pkg;

    // Default table size and generation counter width
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int GEN_BITS_DEF      = 32;

    // Numbers below this are reserved
    localparam int RESERVED_LIMIT = 2;

    // Field widths on the ports
    localparam int NUM_W    = 10;
    localparam int OGEN_W   = 32;
    localparam int ACT_W    = 2;
    localparam int STATUS_W = 3;

    // Request kinds
    localparam logic [ACT_W-1:0] ACT_ALLOC_ANY   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC_GIVEN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE        = 2'd2;
    localparam logic [ACT_W-1:0] ACT_LOOKUP      = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd4;

endpackage
`default_nettype wire

/* hw/rtl/inode_number_allocator.sv */
// Top level: object number allocator with generations and a doubly linked free list.
//
// Input channel s_axis: tuser carries the request kind (allocate any, allocate given,
// free, look up), tdata carries the object number. One beat is one request.
// Output channel m_axis: one beat per request; tuser carries the status, tdata the
// assigned number and the low 32 bits of its generation (both zero on error).
// A small sequencer drives the table memories (state bits, generation, next link,
// previous link), each with one write port and one registered read port.
// Reserved, out-of-range and table-full errors go from accept straight to S_DONE;
// all other requests read the entry (S_READ) and evaluate it (S_EVAL). A free onto a
// non-empty list then adds S_PUSH, and a reuse of a freed entry adds S_UNLINK.
// Allocating at the fresh index steps forward through S_SCAN, S_SCAN_RD and
// S_SCAN_CHK for each entry checked, until an absent entry or the end of the table.
// The block takes one request at a time; s_axis_tready is low while one is at work,
// so a new request is taken only after the last result has moved to the output register.
// A finished result waits in the output register; the next request is accepted
// meanwhile, and the sequencer holds its result until the output register frees.
// After reset a clearing pass (S_CLEAR) zeroes the state bits of every entry;
// s_axis_tready stays low during it.
`default_nettype none
module inode_number_allocator #(
    parameter int TABLE_ENTRIES = ina_pkg::TABLE_ENTRIES_DEF,
    parameter int GEN_BITS      = ina_pkg::GEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [9:0] number
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [9:0] assigned_number, [41:10] generation
    output logic [2:0]       m_axis_tuser    // [2:0] status
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NONE = LW'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EVAL, S_PUSH, S_UNLINK,
        S_SCAN, S_SCAN_RD, S_SCAN_CHK, S_DONE
    } t_state;

    // Table memories
    logic [1:0]          mem_st  [TABLE_ENTRIES];   // {present, in_use}
    logic [GEN_BITS-1:0] mem_gen [TABLE_ENTRIES];
    logic [LW-1:0]       mem_nx  [TABLE_ENTRIES];
    logic [LW-1:0]       mem_pv  [TABLE_ENTRIES];

    logic [1:0]          r_d_st;
    logic [GEN_BITS-1:0] r_d_gen;
    logic [LW-1:0]       r_d_nx, r_d_pv;

    logic                st_we, gen_we, nx_we, pv_we;
    logic [IW-1:0]       st_wa, gen_wa, nx_wa, pv_wa;
    logic [1:0]          st_wd;
    logic [GEN_BITS-1:0] gen_wd;
    logic [LW-1:0]       nx_wd, pv_wd;

    t_state                r_state, n_state;
    logic [ina_pkg::ACT_W-1:0] r_act, n_act;
    logic [IW-1:0]         r_addr, n_addr;
    logic [IW-1:0]         r_n, n_n;
    logic [IW-1:0]         r_clr, n_clr;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_fresh, n_fresh;
    logic [LW-1:0]         r_p, n_p, r_q, n_q;
    logic [ina_pkg::STATUS_W-1:0] r_res_st, n_res_st;
    logic [IW-1:0]         r_res_num, n_res_num;
    logic [GEN_BITS-1:0]   r_res_gen, n_res_gen;
    logic                  r_ovalid, n_ovalid;
    logic [ina_pkg::STATUS_W-1:0] r_o_st, n_o_st;
    logic [ina_pkg::NUM_W-1:0]    r_o_num, n_o_num;
    logic [ina_pkg::OGEN_W-1:0]   r_o_gen, n_o_gen;

    logic [ina_pkg::NUM_W-1:0] in_num;
    logic                      in_valid_num;
    logic                      d_pres, d_use;
    logic [LW-1:0]             fresh_inc;
    logic                      out_free;

    assign in_num       = s_axis_tdata[ina_pkg::NUM_W-1:0];
    assign in_valid_num = (32'(in_num) >= ina_pkg::RESERVED_LIMIT)
                        && (32'(in_num) < TABLE_ENTRIES);
    assign d_pres       = r_d_st[1];
    assign d_use        = r_d_st[0];
    assign fresh_inc    = r_fresh + LW'(1);
    assign out_free     = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_st;
    assign m_axis_tdata  = {6'd0, r_o_gen, r_o_num};

    // Memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (st_we) mem_st[st_wa] <= st_wd;
        r_d_st <= mem_st[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (gen_we) mem_gen[gen_wa] <= gen_wd;
        r_d_gen <= mem_gen[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (nx_we) mem_nx[nx_wa] <= nx_wd;
        r_d_nx <= mem_nx[r_addr];
    end
    always_ff @(posedge i_clk) begin
        if (pv_we) mem_pv[pv_wa] <= pv_wd;
        r_d_pv <= mem_pv[r_addr];
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_addr    = r_addr;
        n_n       = r_n;
        n_clr     = r_clr;
        n_head    = r_head;
        n_fresh   = r_fresh;
        n_p       = r_p;
        n_q       = r_q;
        n_res_st  = r_res_st;
        n_res_num = r_res_num;
        n_res_gen = r_res_gen;
        n_ovalid  = r_ovalid;
        n_o_st    = r_o_st;
        n_o_num   = r_o_num;
        n_o_gen   = r_o_gen;
        st_we  = 1'b0; st_wa  = r_n; st_wd  = 2'b11;
        gen_we = 1'b0; gen_wa = r_n; gen_wd = '0;
        nx_we  = 1'b0; nx_wa  = r_n; nx_wd  = r_head;
        pv_we  = 1'b0; pv_wa  = r_n; pv_wd  = NONE;

        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                st_we = 1'b1;
                st_wa = r_clr;
                st_wd = 2'b00;
                n_clr = r_clr + IW'(1);
                if (r_clr == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act     = s_axis_tuser;
                    n_res_num = '0;
                    n_res_gen = '0;
                    if (s_axis_tuser == ina_pkg::ACT_ALLOC_ANY) begin
                        if (r_head != NONE) begin
                            n_n = r_head[IW-1:0]; n_addr = r_head[IW-1:0];
                            n_state = S_READ;
                        end else if (r_fresh != NONE) begin
                            n_n = r_fresh[IW-1:0]; n_addr = r_fresh[IW-1:0];
                            n_state = S_READ;
                        end else begin
                            n_res_st = ina_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end
                    end else if (!in_valid_num) begin
                        n_res_st = ina_pkg::ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_n = IW'(in_num); n_addr = IW'(in_num);
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_DONE;
                case (r_act)
                    ina_pkg::ACT_LOOKUP: begin
                        if (d_pres && d_use) begin
                            n_res_st = ina_pkg::ST_OK;
                            n_res_num = r_n; n_res_gen = r_d_gen;
                        end else begin
                            n_res_st = ina_pkg::ST_NOT_USED;
                        end
                    end
                    ina_pkg::ACT_FREE: begin
                        if (d_pres && d_use) begin
                            st_we = 1'b1; st_wd = 2'b10;
                            pv_we = 1'b1; pv_wd = NONE;
                            nx_we = 1'b1; nx_wd = r_head;
                            n_p    = r_head;
                            n_head = LW'(r_n);
                            n_res_st = ina_pkg::ST_OK;
                            n_res_num = r_n; n_res_gen = r_d_gen;
                            if (r_head != NONE) n_state = S_PUSH;
                        end else begin
                            n_res_st = ina_pkg::ST_NOT_USED;
                        end
                    end
                    default: begin
                        // Both allocate kinds
                        if (!d_pres) begin
                            st_we  = 1'b1; st_wd = 2'b11;
                            gen_we = 1'b1; gen_wd = '0;
                            n_res_st = ina_pkg::ST_OK;
                            n_res_num = r_n; n_res_gen = '0;
                            if (LW'(r_n) == r_fresh) n_state = S_SCAN;
                        end else if (d_use) begin
                            n_res_st = ina_pkg::ST_BUSY;
                        end else begin
                            st_we  = 1'b1; st_wd = 2'b11;
                            gen_we = 1'b1; gen_wd = r_d_gen + GEN_BITS'(1);
                            n_p = r_d_pv;
                            n_q = r_d_nx;
                            n_res_st = ina_pkg::ST_OK;
                            n_res_num = r_n; n_res_gen = r_d_gen + GEN_BITS'(1);
                            n_state = S_UNLINK;
                        end
                    end
                endcase
            end
            S_PUSH: begin
                // old head points back to the new head
                pv_we = 1'b1; pv_wa = r_p[IW-1:0]; pv_wd = LW'(r_n);
                n_state = S_DONE;
            end
            S_UNLINK: begin
                if (r_p != NONE) begin
                    nx_we = 1'b1; nx_wa = r_p[IW-1:0]; nx_wd = r_q;
                end else begin
                    n_head = r_q;
                end
                if (r_q != NONE) begin
                    pv_we = 1'b1; pv_wa = r_q[IW-1:0]; pv_wd = r_p;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // step the fresh index past present entries
                n_fresh = fresh_inc;
                if (fresh_inc == NONE) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = fresh_inc[IW-1:0];
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: n_state = d_pres ? S_SCAN : S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_o_st   = r_res_st;
                    n_o_num  = ina_pkg::NUM_W'(r_res_num);
                    n_o_gen  = ina_pkg::OGEN_W'(r_res_gen);
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_head   <= NONE;
            r_fresh  <= LW'(ina_pkg::RESERVED_LIMIT);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_fresh  <= n_fresh;
            r_ovalid <= n_ovalid;
        end
        r_act     <= n_act;
        r_addr    <= n_addr;
        r_n       <= n_n;
        r_p       <= n_p;
        r_q       <= n_q;
        r_res_st  <= n_res_st;
        r_res_num <= n_res_num;
        r_res_gen <= n_res_gen;
        r_o_st    <= n_o_st;
        r_o_num   <= n_o_num;
        r_o_gen   <= n_o_gen;
    end

endmodule
`default_nettype wire

/* hw/rtl/ina_checker.sv */
// Port-level checker for the object number allocator, bound to the top level.
`default_nettype none
module ina_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Error results carry zero number and generation
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ina_pkg::ST_OK |-> m_axis_tdata == 48'd0)
        else $error("error result with nonzero payload");

    // Status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == ina_pkg::ST_OK || m_axis_tuser == ina_pkg::ST_RANGE
            || m_axis_tuser == ina_pkg::ST_BUSY || m_axis_tuser == ina_pkg::ST_FULL
            || m_axis_tuser == ina_pkg::ST_NOT_USED)
        else $error("undefined status code");

    // One request at a time: busy in the cycle after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

endmodule

bind inode_number_allocator ina_checker u_ina_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
